// File: rtl/s2a_pkg.sv
package s2a_pkg;

  typedef enum logic [1:0] {
    ModeScan = 2'd0,
    ModeRead = 2'd1,
    ModeTick = 2'd2,
    ModeNone = 2'd3
  } mode_e;

  localparam int unsigned DefaultQueueDepth = 64;

  localparam logic [7:0] PrefixByte = 8'hE0;
  localparam logic [6:0] LShiftCode = 7'h2A;
  localparam logic [6:0] RShiftCode = 7'h36;
  localparam logic [6:0] CapsCode   = 7'h3A;
  localparam logic [6:0] KeyUp      = 7'h48;
  localparam logic [6:0] KeyDown    = 7'h50;
  localparam logic [6:0] KeyLeft    = 7'h4B;
  localparam logic [6:0] KeyRight   = 7'h4D;
  localparam logic [6:0] KeyDelete  = 7'h53;
  localparam logic [6:0] RomSize    = 7'd58;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] scan_byte;
  } in_t;

  typedef struct packed {
    logic        event_valid;
    logic [6:0]  key_code;
    logic [6:0]  character;
    logic [31:0] stamp;
    logic        shift_held;
    logic        caps_on;
  } out_t;

  typedef struct packed {
    logic [6:0]  key_code;
    logic [6:0]  character;
    logic [31:0] stamp;
  } entry_t;

  localparam logic [6:0] RomPlain [58] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] RomShifted [58] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  function automatic logic [6:0] ascii_lookup(logic [6:0] key, logic upper);
    logic [6:0] chr;
    chr = 7'h00;
    if (key < RomSize) begin
      chr = upper ? RomShifted[key[5:0]] : RomPlain[key[5:0]];
    end
    return chr;
  endfunction

endpackage

// File: rtl/s2a_event_queue.sv
module s2a_event_queue #(
  parameter int unsigned QueueDepth = s2a_pkg::DefaultQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  s2a_pkg::entry_t push_data_i,
  input  logic            pop_i,
  output s2a_pkg::entry_t pop_data_o,
  output logic            empty_o
);

  localparam int unsigned PtrW  = $clog2(QueueDepth);
  localparam int unsigned FillW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0]  LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [FillW-1:0] FullLvl = FillW'(QueueDepth);

  s2a_pkg::entry_t mem [QueueDepth];
  s2a_pkg::entry_t rdata_q;

  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             full;

  assign full    = (fill_q == FullLvl);
  assign empty_o = (fill_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (full) begin
        // overwrite: oldest entry goes
        rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end else if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      fill_d   = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  // read data holds until the next pop
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  assign pop_data_o = rdata_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullLvl) else $error("fill level above depth");

  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && pop_i)) else $error("push and pop in one cycle");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

  a_full_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && full) |=> full) else $error("overwrite changed fill level");

endmodule

// File: rtl/scancode_to_ascii_event_queue_top.sv
// Set-1 scancode translator with a timestamped event queue.
// Input channel (in_valid_i / in_stall_o / in_i) carries one transaction per
// item: mode 0 a scancode byte, mode 1 a read of one queued event, mode 2 a
// timer tick, mode 3 is ignored. Only reads produce a result on the output
// channel (out_valid_o / out_stall_i / out_o); an empty queue gives a result
// with event_valid clear.
// Throughput: one item per cycle while in_stall_o is low. A read passes from
// accept through the registered read of the event memory (stage s1) and then
// the output register to out_valid_o.
// The queue is a QueueDepth-entry single-port-per-side memory; a full queue
// overwrites its oldest event.
// Reset clears the shift, caps, prefix state, the tick count and the queue
// pointers; memory contents are left as they are and no clearing pass runs.
// When the receiver stalls, the result holds in the output register and one
// more read can wait behind it; after that in_stall_o rises until it drains.
module scancode_to_ascii_event_queue_top #(
  parameter int unsigned QueueDepth = s2a_pkg::DefaultQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  s2a_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output s2a_pkg::out_t out_o
);

  logic in_acc;
  logic [6:0] key;
  logic rel;

  logic prefix_q, prefix_d;
  logic caps_q, caps_d;
  logic lshift_q, lshift_d;
  logic rshift_q, rshift_d;
  logic [31:0] tick_q, tick_d;

  logic            push;
  logic [6:0]      push_chr;
  s2a_pkg::entry_t push_data;
  logic            rd_acc;
  logic            pop;
  logic            empty;
  s2a_pkg::entry_t pop_data;

  // read waiting for memory data
  logic s1_valid_q, s1_hit_q, s1_shift_q, s1_caps_q;
  logic s1_move;
  logic out_valid_q;
  s2a_pkg::out_t out_q;

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign key = in_i.scan_byte[6:0];
  assign rel = in_i.scan_byte[7];

  always_comb begin
    prefix_d = prefix_q;
    caps_d   = caps_q;
    lshift_d = lshift_q;
    rshift_d = rshift_q;
    tick_d   = tick_q;
    push     = 1'b0;
    push_chr = 7'h00;
    if (in_acc && in_i.mode == s2a_pkg::ModeScan) begin
      if (in_i.scan_byte == s2a_pkg::PrefixByte) begin
        prefix_d = 1'b1;
      end else if (prefix_q) begin
        prefix_d = 1'b0;
        if (!rel && (key == s2a_pkg::KeyUp || key == s2a_pkg::KeyDown ||
                     key == s2a_pkg::KeyLeft || key == s2a_pkg::KeyRight ||
                     key == s2a_pkg::KeyDelete)) begin
          push = 1'b1;
        end
      end else if (key == s2a_pkg::CapsCode) begin
        if (!rel) begin
          caps_d = !caps_q;
        end
      end else if (key < s2a_pkg::RomSize) begin
        if (key == s2a_pkg::LShiftCode) begin
          lshift_d = !rel;
        end else if (key == s2a_pkg::RShiftCode) begin
          rshift_d = !rel;
        end else if (!rel) begin
          push     = 1'b1;
          push_chr = s2a_pkg::ascii_lookup(key, (lshift_q || rshift_q) != caps_q);
        end
      end
    end
    if (in_acc && in_i.mode == s2a_pkg::ModeTick) begin
      tick_d = tick_q + 32'd1;
    end
  end

  assign push_data = '{key_code: key, character: push_chr, stamp: tick_q};
  assign rd_acc    = in_acc && (in_i.mode == s2a_pkg::ModeRead);
  assign pop       = rd_acc && !empty;

  s2a_event_queue #(
    .QueueDepth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= 1'b0;
      caps_q      <= 1'b0;
      lshift_q    <= 1'b0;
      rshift_q    <= 1'b0;
      tick_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prefix_q <= prefix_d;
      caps_q   <= caps_d;
      lshift_q <= lshift_d;
      rshift_q <= rshift_d;
      tick_q   <= tick_d;
      if (rd_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_acc) begin
      s1_hit_q   <= !empty;
      s1_shift_q <= lshift_q || rshift_q;
      s1_caps_q  <= caps_q;
    end
    if (s1_move) begin
      out_q.event_valid <= s1_hit_q;
      out_q.key_code    <= s1_hit_q ? pop_data.key_code : 7'h00;
      out_q.character   <= s1_hit_q ? pop_data.character : 7'h00;
      out_q.stamp       <= s1_hit_q ? pop_data.stamp : 32'h0;
      out_q.shift_held  <= s1_shift_q;
      out_q.caps_on     <= s1_caps_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> s1_valid_q)
    else $error("pending read lost");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> !in_acc)
    else $error("read accepted with pipeline full");

endmodule
